@@ rtl/shsq_pkg.sv @@
// ----------------------------------------------------------------------------
// shsq_pkg: shared types and constants of the homing sequencer
// Phase codes, motion codes, register indexes, reset values and the word
// layouts that pass between the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shsq_pkg;

  localparam int unsigned TimerW    = 24;
  localparam int unsigned IntervalW = 20;
  localparam int unsigned ReadingW  = 10;
  localparam int unsigned RunW      = 8;
  localparam int unsigned StepCntW  = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [RunW-1:0]   RunMax   = {RunW{1'b1}};

  // Sequencer phase, one-hot inside the block
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SEEK1   = 5'b00010,
    PH_SETTLE  = 5'b00100,
    PH_SEEK2   = 5'b01000,
    PH_BACKOFF = 5'b10000
  } phase_e;

  // Phase codes as reported on the result word
  localparam logic [2:0] PHASE_CODE_IDLE    = 3'd0;
  localparam logic [2:0] PHASE_CODE_SEEK1   = 3'd1;
  localparam logic [2:0] PHASE_CODE_SETTLE  = 3'd2;
  localparam logic [2:0] PHASE_CODE_SEEK2   = 3'd3;
  localparam logic [2:0] PHASE_CODE_BACKOFF = 3'd4;

  // External motion command
  localparam logic [1:0] MC_RUN   = 2'd0;
  localparam logic [1:0] MC_PAUSE = 2'd1;
  localparam logic [1:0] MC_ABORT = 2'd2;

  localparam logic CMD_START = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STALL_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_DELAY     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHECKS_NEEDED   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SEEK_TIMEOUT    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE          = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STEP_INTERVAL   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF_STEPS   = 3'd7;

  // Reset values
  localparam logic [ReadingW-1:0]  RST_STALL_THRESHOLD = 10'd100;
  localparam logic [IntervalW-1:0] RST_CHECK_INTERVAL  = 20'd10000;
  localparam logic [TimerW-1:0]    RST_START_DELAY     = 24'd500000;
  localparam logic [RunW-1:0]      RST_CHECKS_NEEDED   = 8'd3;
  localparam logic [TimerW-1:0]    RST_SEEK_TIMEOUT    = 24'd10000000;
  localparam logic [TimerW-1:0]    RST_SETTLE          = 24'd500000;
  localparam logic [IntervalW-1:0] RST_STEP_INTERVAL   = 20'd1000;
  localparam logic [StepCntW-1:0]  RST_BACKOFF_STEPS   = 16'd240;

  // Settings as the step logic sees them (intervals already forced to >= 1)
  typedef struct packed {
    logic [ReadingW-1:0]  stall_threshold;
    logic [IntervalW-1:0] check_step;
    logic [TimerW-1:0]    seek_load;
    logic [RunW-1:0]      checks_needed;
    logic [TimerW-1:0]    seek_timeout;
    logic [TimerW-1:0]    settle;
    logic [IntervalW-1:0] step_step;
    logic [StepCntW-1:0]  backoff_steps;
  } cfg_t;

  typedef struct packed {
    phase_e               phase;
    logic                 hold;
    logic [TimerW-1:0]    check_timer;
    logic [TimerW-1:0]    elapsed;
    logic [RunW-1:0]      stall_run;
    logic [StepCntW-1:0]  step_cnt;
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [1:0]           motion;
    logic [ReadingW-1:0]  stall_a;
    logic [ReadingW-1:0]  stall_b;
  } item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       paused;
    logic       drive_a_on;
    logic       drive_a_fwd;
    logic       drive_b_on;
    logic       drive_b_fwd;
    logic       step_pulse;
    logic       zero_position;
    logic       finished;
    logic       aborted;
  } result_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_SEEK1:   code = PHASE_CODE_SEEK1;
      PH_SETTLE:  code = PHASE_CODE_SETTLE;
      PH_SEEK2:   code = PHASE_CODE_SEEK2;
      PH_BACKOFF: code = PHASE_CODE_BACKOFF;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [TimerW-1:0] sat_inc(logic [TimerW-1:0] v);
    logic [TimerW-1:0] r;
    r = (v == TimerMax) ? TimerMax : v + TimerW'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/shsq_cfg.sv @@
// ----------------------------------------------------------------------------
// shsq_cfg: configuration registers of the homing sequencer
// Holds the eight settings and the derived values the step logic needs.
// ----------------------------------------------------------------------------
`default_nettype none

module shsq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [shsq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shsq_pkg::CfgDataW-1:0] cfg_data_i,
  output shsq_pkg::cfg_t                cfg_o
);
  import shsq_pkg::*;

  logic [ReadingW-1:0]  stall_threshold_q;
  logic [IntervalW-1:0] check_interval_q;
  logic [TimerW-1:0]    start_delay_q;
  logic [RunW-1:0]      checks_needed_q;
  logic [TimerW-1:0]    seek_timeout_q;
  logic [TimerW-1:0]    settle_q;
  logic [IntervalW-1:0] step_interval_q;
  logic [StepCntW-1:0]  backoff_steps_q;

  logic [IntervalW-1:0] check_step;
  logic [IntervalW-1:0] step_step;
  logic [TimerW:0]      load_sum;
  logic [TimerW-1:0]    seek_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_threshold_q <= RST_STALL_THRESHOLD;
      check_interval_q  <= RST_CHECK_INTERVAL;
      start_delay_q     <= RST_START_DELAY;
      checks_needed_q   <= RST_CHECKS_NEEDED;
      seek_timeout_q    <= RST_SEEK_TIMEOUT;
      settle_q          <= RST_SETTLE;
      step_interval_q   <= RST_STEP_INTERVAL;
      backoff_steps_q   <= RST_BACKOFF_STEPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALL_THRESHOLD: stall_threshold_q <= cfg_data_i[ReadingW-1:0];
        CFG_CHECK_INTERVAL:  check_interval_q  <= cfg_data_i[IntervalW-1:0];
        CFG_START_DELAY:     start_delay_q     <= cfg_data_i[TimerW-1:0];
        CFG_CHECKS_NEEDED:   checks_needed_q   <= cfg_data_i[RunW-1:0];
        CFG_SEEK_TIMEOUT:    seek_timeout_q    <= cfg_data_i[TimerW-1:0];
        CFG_SETTLE:          settle_q          <= cfg_data_i[TimerW-1:0];
        CFG_STEP_INTERVAL:   step_interval_q   <= cfg_data_i[IntervalW-1:0];
        CFG_BACKOFF_STEPS:   backoff_steps_q   <= cfg_data_i[StepCntW-1:0];
        default: ;
      endcase
    end
  end

  // A zero interval acts as one
  assign check_step = (check_interval_q == '0) ? IntervalW'(1) : check_interval_q;
  assign step_step  = (step_interval_q == '0) ? IntervalW'(1) : step_interval_q;

  // Seek entry load: start delay plus one interval, saturated
  assign load_sum  = {1'b0, start_delay_q} + {{(TimerW + 1 - IntervalW){1'b0}}, check_step};
  assign seek_load = load_sum[TimerW] ? TimerMax : load_sum[TimerW-1:0];

  assign cfg_o.stall_threshold = stall_threshold_q;
  assign cfg_o.check_step      = check_step;
  assign cfg_o.seek_load       = seek_load;
  assign cfg_o.checks_needed   = checks_needed_q;
  assign cfg_o.seek_timeout    = seek_timeout_q;
  assign cfg_o.settle          = settle_q;
  assign cfg_o.step_step       = step_step;
  assign cfg_o.backoff_steps   = backoff_steps_q;

endmodule

`default_nettype wire

@@ rtl/shsq_step.sv @@
// ----------------------------------------------------------------------------
// shsq_step: one-tick transition of the homing sequencer
// Takes the held state and one tick word, gives the next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module shsq_step (
  input  shsq_pkg::state_t  state_i,
  input  shsq_pkg::item_t   item_i,
  input  shsq_pkg::cfg_t    cfg_i,
  output shsq_pkg::state_t  state_o,
  output shsq_pkg::result_t result_o
);
  import shsq_pkg::*;

  localparam state_t IdleState = '{phase: PH_IDLE, default: '0};

  logic                 busy;
  logic                 stalled;
  logic [RunW-1:0]      run_inc;
  logic [TimerW-1:0]    check_load;
  logic [TimerW-1:0]    step_load;
  logic [TimerW-1:0]    el_inc;

  assign busy = (state_i.phase == PH_SEEK1) || (state_i.phase == PH_SETTLE) ||
                (state_i.phase == PH_SEEK2) || (state_i.phase == PH_BACKOFF);
  assign stalled = (item_i.stall_a < cfg_i.stall_threshold) ||
                   (item_i.stall_b < cfg_i.stall_threshold);
  assign run_inc    = (state_i.stall_run == RunMax) ? RunMax
                                                    : state_i.stall_run + RunW'(1);
  assign check_load = TimerW'(cfg_i.check_step);
  assign step_load  = TimerW'(cfg_i.step_step);
  assign el_inc     = sat_inc(state_i.elapsed);

  always_comb begin
    logic done;
    state_o  = state_i;
    result_o = '0;
    done     = 1'b0;

    if (!busy) begin
      state_o = IdleState;
      if ((item_i.start == CMD_START) && (item_i.motion != MC_ABORT)) begin
        state_o.phase       = PH_SEEK1;
        state_o.check_timer = cfg_i.seek_load;
        state_o.hold        = (item_i.motion == MC_PAUSE);
      end
    end else if (item_i.motion == MC_ABORT) begin
      state_o          = IdleState;
      result_o.aborted = 1'b1;
    end else if (item_i.motion == MC_PAUSE) begin
      state_o.hold = 1'b1;
      case (state_i.phase)
        PH_SEEK1, PH_SEEK2: begin
          state_o.check_timer = check_load;
          state_o.elapsed     = '0;
        end
        PH_SETTLE: begin
          state_o.elapsed = el_inc;
        end
        default: ;
      endcase
    end else begin
      state_o.hold = 1'b0;
      case (state_i.phase)
        PH_SEEK1, PH_SEEK2: begin
          state_o.elapsed = el_inc;
          if (state_i.check_timer > TimerW'(1)) begin
            state_o.check_timer = state_i.check_timer - TimerW'(1);
          end else begin
            state_o.check_timer = check_load;
            if (stalled) begin
              state_o.stall_run = run_inc;
              done = (run_inc >= cfg_i.checks_needed);
            end else begin
              state_o.stall_run = '0;
            end
            if (el_inc > cfg_i.seek_timeout) begin
              done = 1'b1;
            end
          end
          if (done) begin
            state_o.stall_run = '0;
            state_o.elapsed   = '0;
            if (state_i.phase == PH_SEEK1) begin
              state_o.phase = PH_SETTLE;
            end else begin
              state_o.phase       = PH_BACKOFF;
              state_o.step_cnt    = '0;
              state_o.check_timer = TimerW'(1);
            end
          end
        end
        PH_SETTLE: begin
          state_o.elapsed = el_inc;
          if (el_inc >= cfg_i.settle) begin
            state_o.phase       = PH_SEEK2;
            state_o.check_timer = cfg_i.seek_load;
            state_o.elapsed     = '0;
            state_o.stall_run   = '0;
          end
        end
        default: begin
          // back-off
          if (state_i.check_timer > TimerW'(1)) begin
            state_o.check_timer = state_i.check_timer - TimerW'(1);
          end else if (state_i.step_cnt < cfg_i.backoff_steps) begin
            result_o.step_pulse = 1'b1;
            state_o.step_cnt    = state_i.step_cnt + StepCntW'(1);
            state_o.check_timer = step_load;
          end else begin
            result_o.zero_position = 1'b1;
            result_o.finished      = 1'b1;
            state_o                = IdleState;
          end
        end
      endcase
    end

    result_o.phase  = phase_code(state_o.phase);
    result_o.paused = state_o.hold;
    if (!state_o.hold && ((state_o.phase == PH_SEEK1) || (state_o.phase == PH_SEEK2))) begin
      result_o.drive_a_on  = 1'b1;
      result_o.drive_b_on  = 1'b1;
      result_o.drive_b_fwd = (state_o.phase == PH_SEEK2);
    end
  end

endmodule

`default_nettype wire

@@ rtl/stall_sensing_homing_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// stall_sensing_homing_sequencer_core: sensorless two-axis homing sequencer
// Input register, one-tick transition logic and result register, with the
// configuration registers beside them.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              word
//  --------  ----  ---------------------  ---------------------------------
//  s_axis    in    tvalid/tready          tick: tdata readings, tuser start
//  m_axis    out   tvalid/tready          result of one tick in tdata
//  cfg       in    cfg_we_i, no stall     register index and write data
//
//  One tick word per cycle, sustained while m_axis is ready: a word is held
//  in the input register, its transition runs through shsq_step, and the
//  result lands in the result register.
//  The input register takes a new word whenever it empties in the same cycle,
//  which only an unready m_axis prevents; a stall on m_axis holds both words.
//  Reset idles the sequencer and loads the documented register defaults.
//
`default_nettype none

module stall_sensing_homing_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] motion_cmd, [11:2] stall_a, [21:12] stall_b, [23:22] zero
  input  logic [shsq_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                          s_axis_tuser,
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] phase, [3] paused, [4] drive_a_on, [5] drive_a_fwd, [6] drive_b_on,
  // [7] drive_b_fwd, [8] step_pulse, [9] zero_position, [10] finished,
  // [11] aborted, [15:12] zero
  output logic [shsq_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [shsq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shsq_pkg::CfgDataW-1:0] cfg_data_i
);
  import shsq_pkg::*;

  localparam state_t IdleState = '{phase: PH_IDLE, default: '0};

  cfg_t    cfg;
  logic    in_valid_q;
  item_t   in_q;
  state_t  state_q, state_d;
  logic    out_valid_q;
  result_t out_q, res_d;
  logic    advance;

  shsq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held tick when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Tick payload: capture on accept, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.start   <= s_axis_tuser;
      in_q.motion  <= s_axis_tdata[1:0];
      in_q.stall_a <= s_axis_tdata[11:2];
      in_q.stall_b <= s_axis_tdata[21:12];
    end
  end

  shsq_step u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state moves only when a tick is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleState;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          out_q.aborted, out_q.finished, out_q.zero_position,
                          out_q.step_pulse, out_q.drive_b_fwd, out_q.drive_b_on,
                          out_q.drive_a_fwd, out_q.drive_a_on, out_q.paused,
                          out_q.phase};

`ifndef SYNTHESIS
  // Zeroing and completion always come together
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.finished == out_q.zero_position))
    else $error("finished without zero_position or the reverse");

  // Drives run only in an unpaused seek
  a_drive_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.drive_a_on) |->
      (!out_q.paused &&
       ((out_q.phase == PHASE_CODE_SEEK1) || (out_q.phase == PHASE_CODE_SEEK2))))
    else $error("drive on outside an active seek");

  // Idle carries no leftover timer or hold
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |->
      ((state_q.check_timer == '0) && !state_q.hold && (state_q.step_cnt == '0)))
    else $error("idle state not cleared");

  // A held tick stays until it is consumed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("held tick lost or changed");

  // Abort always lands in idle
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.aborted) |=> (state_q.phase == PH_IDLE))
    else $error("abort did not return to idle");
`endif

endmodule

`default_nettype wire
